/* design/rec709_inverse_gamma_rgb_unpack_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the inverse gamma unpack unit
// Clocked property checks used by the RTL files, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef REC709_INVERSE_GAMMA_RGB_UNPACK_UNIT_DEFINES_SVH
`define REC709_INVERSE_GAMMA_RGB_UNPACK_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define RI709_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, also during reset
`define RI709_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/ri709_pkg.sv */
// ----------------------------------------------------------------------------
// ri709_pkg
// Shared types and constants of the inverse gamma unpack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ri709_pkg;

  localparam int FRAC_W    = 32;            // internal fraction width
  localparam int COUNT_W   = 24;            // pixel counter width
  localparam int CFG_IDX_W = 8;             // config index width
  localparam int CFG_DAT_W = 24;            // config data width
  localparam int DIV_STEPS = 64;            // quotient bits per division
  localparam int ROOT_BITS = 32;            // bits of the ninth root

  localparam logic [CFG_IDX_W-1:0] REG_MAX_COLOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_EN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_FMT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIX_LIMIT = 8'd3;

  typedef enum logic [1:0] {
    BR_DISABLED,
    BR_LINEAR,
    BR_FULL,
    BR_POWER
  } branch_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_DIV, ST_LDONE, ST_RINIT,
    ST_RSQ, ST_RQ, ST_RO, ST_RN, ST_RCMP,
    ST_P2, ST_P4, ST_P8, ST_P16, ST_P20, ST_SCALE, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_DIV_STEP, CMD_LIN_DONE, CMD_ROOT_INIT,
    CMD_R_SQ, CMD_R_Q, CMD_R_O, CMD_R_N, CMD_R_CMP,
    CMD_P_SQ, CMD_P_4, CMD_P_8, CMD_P_16, CMD_P_20, CMD_SCALE, CMD_OUT_LOAD
  } cmd_t;

  typedef struct packed {
    logic    produce;   // an accepted word completes a sample
    branch_t branch;    // evaluation path of the latched sample
    logic    out_free;  // output register can take a word
  } dp_status_t;

endpackage

`default_nettype wire

/* design/rec709_inverse_gamma_rgb_unpack_unit.sv */
// ----------------------------------------------------------------------------
// rec709_inverse_gamma_rgb_unpack_unit
// Unpacks raw PPM pixel bytes into R, G, B samples and linearizes each one.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data_byte carry raw pixel bytes, one word per
//   handshake. With max_color above 255, two words form one sample, high
//   byte first. Each completed sample yields one out_ word: component,
//   sample_value, enabled, last (last marks the blue sample of the final
//   pixel; further bytes are then consumed without result).
//   cfg_valid/cfg_ready/cfg_index/cfg_data write registers 0..3; any write
//   to those clears the stream position. cfg_ready is always high.
// Evaluation, per sample: a disabled or full-scale sample goes straight
//   to the output load; a linear sample runs the 64-step restoring
//   divider; a power sample runs that divider and the 32-bit ninth-root
//   search on one shared 32x32 multiplier (powers up to the ninth, then
//   a compare, per root bit), plus five passes for ^20 and a scaling.
//   A first byte of a two-byte sample is only stored as the high byte.
// A finished result waits in the output register while the next word is
// accepted; a stalled receiver holds evaluation only at the final load.
// Reset restores max_color 255, all components enabled, integer format,
// pixel limit 1, and clears the stream position.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rec709_inverse_gamma_rgb_unpack_unit_defines.svh"

module rec709_inverse_gamma_rgb_unpack_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       in_data_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            out_component,
  output logic [16:0]                           out_sample_value,
  output logic                                  out_enabled,
  output logic                                  out_last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ri709_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ri709_pkg::CFG_DAT_W-1:0]  cfg_data
);

  ri709_pkg::cmd_t       cmd;
  ri709_pkg::dp_status_t st;
  logic                  in_fire;
  logic                  cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;

  ri709_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ri709_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_fire          (in_fire),
    .in_data_byte     (in_data_byte),
    .cfg_fire         (cfg_fire),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_component    (out_component),
    .out_sample_value (out_sample_value),
    .out_enabled      (out_enabled),
    .out_last         (out_last)
  );

  `RI709_ASSERT(a_last_is_blue,
    (out_valid && out_last) |-> (out_component == 2'd2),
    "last flag on a non-blue sample")
  `RI709_ASSERT(a_disabled_zero,
    (out_valid && !out_enabled) |-> (out_sample_value == 17'd0),
    "disabled sample carries a value")
  `RI709_ASSERT_ALWAYS(a_reset_clears_out,
    !rst_n |=> !out_valid,
    "output valid after reset")

endmodule

`default_nettype wire

/* design/ri709_ctrl.sv */
// ----------------------------------------------------------------------------
// ri709_ctrl
// Sequencer: steps the datapath through divide, root search and scaling.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rec709_inverse_gamma_rgb_unpack_unit_defines.svh"

module ri709_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ri709_pkg::dp_status_t st,
  output ri709_pkg::cmd_t          cmd
);

  ri709_pkg::state_t state_r, state_nxt;
  logic [5:0]        cnt_r, cnt_nxt;

  // Hold state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ri709_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = ri709_pkg::CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ri709_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && st.produce) state_nxt = ri709_pkg::ST_LOAD;
      end
      ri709_pkg::ST_LOAD: begin
        cmd     = ri709_pkg::CMD_LOAD;
        cnt_nxt = '0;
        if (st.branch == ri709_pkg::BR_DISABLED || st.branch == ri709_pkg::BR_FULL)
          state_nxt = ri709_pkg::ST_EMIT;
        else
          state_nxt = ri709_pkg::ST_DIV;
      end
      ri709_pkg::ST_DIV: begin
        cmd     = ri709_pkg::CMD_DIV_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(ri709_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (st.branch == ri709_pkg::BR_LINEAR) ? ri709_pkg::ST_LDONE
                                                          : ri709_pkg::ST_RINIT;
        end
      end
      ri709_pkg::ST_LDONE: begin
        cmd       = ri709_pkg::CMD_LIN_DONE;
        state_nxt = ri709_pkg::ST_EMIT;
      end
      ri709_pkg::ST_RINIT: begin
        cmd       = ri709_pkg::CMD_ROOT_INIT;
        state_nxt = ri709_pkg::ST_RSQ;
      end
      ri709_pkg::ST_RSQ: begin
        cmd = ri709_pkg::CMD_R_SQ; state_nxt = ri709_pkg::ST_RQ;
      end
      ri709_pkg::ST_RQ: begin
        cmd = ri709_pkg::CMD_R_Q; state_nxt = ri709_pkg::ST_RO;
      end
      ri709_pkg::ST_RO: begin
        cmd = ri709_pkg::CMD_R_O; state_nxt = ri709_pkg::ST_RN;
      end
      ri709_pkg::ST_RN: begin
        cmd = ri709_pkg::CMD_R_N; state_nxt = ri709_pkg::ST_RCMP;
      end
      ri709_pkg::ST_RCMP: begin
        cmd     = ri709_pkg::CMD_R_CMP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(ri709_pkg::ROOT_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ri709_pkg::ST_P2;
        end else begin
          state_nxt = ri709_pkg::ST_RSQ;
        end
      end
      ri709_pkg::ST_P2: begin
        cmd = ri709_pkg::CMD_P_SQ; state_nxt = ri709_pkg::ST_P4;
      end
      ri709_pkg::ST_P4: begin
        cmd = ri709_pkg::CMD_P_4; state_nxt = ri709_pkg::ST_P8;
      end
      ri709_pkg::ST_P8: begin
        cmd = ri709_pkg::CMD_P_8; state_nxt = ri709_pkg::ST_P16;
      end
      ri709_pkg::ST_P16: begin
        cmd = ri709_pkg::CMD_P_16; state_nxt = ri709_pkg::ST_P20;
      end
      ri709_pkg::ST_P20: begin
        cmd = ri709_pkg::CMD_P_20; state_nxt = ri709_pkg::ST_SCALE;
      end
      ri709_pkg::ST_SCALE: begin
        cmd = ri709_pkg::CMD_SCALE; state_nxt = ri709_pkg::ST_EMIT;
      end
      ri709_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd       = ri709_pkg::CMD_OUT_LOAD;
          state_nxt = ri709_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ri709_pkg::ST_IDLE;
    endcase
  end

  `RI709_ASSERT(a_emit_needs_slot,
    (cmd == ri709_pkg::CMD_OUT_LOAD) |-> st.out_free,
    "output register loaded while occupied")
  `RI709_ASSERT(a_sample_starts_load,
    (state_r == ri709_pkg::ST_IDLE && in_valid && st.produce) |=>
      (state_r == ri709_pkg::ST_LOAD),
    "completed sample did not start evaluation")
  `RI709_ASSERT(a_div_count_bound,
    (state_r == ri709_pkg::ST_RCMP) |-> (cnt_r < 6'(ri709_pkg::ROOT_BITS)),
    "root bit counter out of range")

endmodule

`default_nettype wire

/* design/ri709_dp.sv */
// ----------------------------------------------------------------------------
// ri709_dp
// Datapath: stream unpacking, config registers, divider, shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ri709_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ri709_pkg::cmd_t                       cmd,
  output ri709_pkg::dp_status_t                      st,
  input  wire logic                                  in_fire,
  input  wire logic [7:0]                            in_data_byte,
  input  wire logic                                  cfg_fire,
  input  wire logic [ri709_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ri709_pkg::CFG_DAT_W-1:0]       cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [1:0]                                 out_component,
  output logic [16:0]                                out_sample_value,
  output logic                                       out_enabled,
  output logic                                       out_last
);

  localparam int FW = ri709_pkg::FRAC_W;
  localparam int CW = ri709_pkg::COUNT_W;

  // configuration and stream state
  logic [15:0]   mc_r;
  logic [2:0]    en_r;
  logic          fmt_r;
  logic [CW-1:0] lim_r;
  logic [7:0]    hb_r;
  logic          ph_r;
  logic [1:0]    ci_r;
  logic [CW-1:0] pd_r;
  logic          fin_r;

  // latched sample
  logic [15:0]   w_r, mm_r;
  logic [16:0]   s_r;
  logic [1:0]    comp_r;
  logic          sen_r, slast_r;

  // arithmetic registers
  logic [26:0]   rem_r, dvs_r;
  logic [63:0]   dvd_r, q_r;
  logic [FW-1:0] r_r, u_r, bm_r, t1_r, t2_r;
  logic [16:0]   val_r;
  logic          out_valid_r;

  logic [15:0]   m_eff;
  logic          wide;
  logic [15:0]   w_raw, w_cl;
  logic [1:0]    comp_c;
  logic [CW-1:0] lim_eff, pd_inc;
  logic [25:0]   w1000;
  logic [22:0]   m81;
  logic [34:0]   lin_num;
  logic [26:0]   a_pow, den_pow;
  logic [27:0]   rem2;
  logic          ge;
  logic [FW-1:0] cand, opa, opb;
  logic [2*FW-1:0] prod;
  logic [48:0]   scaled;

  // Decode stream position
  assign m_eff   = (mc_r == 16'd0) ? 16'd1 : mc_r;
  assign wide    = (m_eff > 16'd255);
  assign w_raw   = wide ? {hb_r, in_data_byte} : {8'd0, in_data_byte};
  assign w_cl    = (w_raw > m_eff) ? m_eff : w_raw;
  assign comp_c  = (ci_r > 2'd2) ? 2'd2 : ci_r;
  assign lim_eff = (lim_r == '0) ? CW'(1) : lim_r;
  assign pd_inc  = pd_r + CW'(1);

  // Classify the latched sample
  assign w1000   = 26'(w_r) * 26'd1000;
  assign m81     = 23'(mm_r) * 23'd81;
  assign lin_num = (35'(w_r) * 35'(s_r) << 2) + 35'(mm_r) * 35'd9;
  assign a_pow   = 27'(w1000) + 27'(mm_r) * 27'd99;
  assign den_pow = 27'(mm_r) * 27'd1099;

  // Report branch, sample completion and output slot
  always_comb begin
    if (!sen_r)                        st.branch = ri709_pkg::BR_DISABLED;
    else if (w1000 < 26'(m81))         st.branch = ri709_pkg::BR_LINEAR;
    else if (w_r == mm_r)              st.branch = ri709_pkg::BR_FULL;
    else                               st.branch = ri709_pkg::BR_POWER;
    st.produce  = !fin_r && !(wide && !ph_r);
    st.out_free = !out_valid_r || out_ready;
  end

  // Divider step
  assign rem2 = {rem_r, dvd_r[63]};
  assign ge   = (rem2 >= {1'b0, dvs_r});

  // Shared multiplier operand select
  assign cand = u_r | bm_r;
  always_comb begin
    opa = t1_r;
    opb = t1_r;
    case (cmd)
      ri709_pkg::CMD_R_SQ: begin opa = cand; opb = cand; end
      ri709_pkg::CMD_R_Q:  begin opa = t1_r; opb = t1_r; end
      ri709_pkg::CMD_R_O:  begin opa = t2_r; opb = t2_r; end
      ri709_pkg::CMD_R_N:  begin opa = t1_r; opb = cand; end
      ri709_pkg::CMD_P_SQ: begin opa = u_r;  opb = u_r;  end
      ri709_pkg::CMD_P_4:  begin opa = t1_r; opb = t1_r; end
      ri709_pkg::CMD_P_8:  begin opa = t2_r; opb = t2_r; end
      ri709_pkg::CMD_P_16: begin opa = t1_r; opb = t1_r; end
      ri709_pkg::CMD_P_20: begin opa = t1_r; opb = t2_r; end
      default:             begin opa = t1_r; opb = t1_r; end
    endcase
  end
  assign prod   = opa * opb;
  assign scaled = 49'(t1_r) * 49'(s_r) + (49'd1 << (FW - 1));

  // Config and stream control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r  <= 16'd255;
      en_r  <= 3'd7;
      fmt_r <= 1'b0;
      lim_r <= CW'(1);
      hb_r  <= '0;
      ph_r  <= 1'b0;
      ci_r  <= '0;
      pd_r  <= '0;
      fin_r <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        ri709_pkg::REG_MAX_COLOR: mc_r  <= cfg_data[15:0];
        ri709_pkg::REG_COMP_EN:   en_r  <= cfg_data[2:0];
        ri709_pkg::REG_OUT_FMT:   fmt_r <= cfg_data[0];
        ri709_pkg::REG_PIX_LIMIT: lim_r <= cfg_data[CW-1:0];
        default: ;
      endcase
      if (cfg_index <= ri709_pkg::REG_PIX_LIMIT) begin
        hb_r  <= '0;
        ph_r  <= 1'b0;
        ci_r  <= '0;
        pd_r  <= '0;
        fin_r <= 1'b0;
      end
    end else if (in_fire && !fin_r) begin
      if (wide && !ph_r) begin
        hb_r <= in_data_byte;
        ph_r <= 1'b1;
      end else begin
        ph_r <= 1'b0;
        if (comp_c == 2'd2) begin
          ci_r <= '0;
          pd_r <= pd_inc;
          if (pd_inc == lim_eff) fin_r <= 1'b1;
        end else begin
          ci_r <= comp_c + 2'd1;
        end
      end
    end
  end

  // Latch the completed sample
  always_ff @(posedge clk) begin
    if (in_fire && st.produce) begin
      w_r     <= w_cl;
      mm_r    <= m_eff;
      s_r     <= fmt_r ? 17'h10000 : {1'b0, m_eff};
      comp_r  <= comp_c;
      sen_r   <= en_r[comp_c];
      slast_r <= (comp_c == 2'd2) && (pd_inc == lim_eff);
    end
  end

  // Arithmetic sequence
  always_ff @(posedge clk) begin
    case (cmd)
      ri709_pkg::CMD_LOAD: begin
        rem_r <= '0;
        q_r   <= '0;
        if (st.branch == ri709_pkg::BR_LINEAR) begin
          dvd_r <= 64'(lin_num);
          dvs_r <= 27'(mm_r) * 27'd18;
        end else begin
          dvd_r <= {5'd0, a_pow, 32'd0};
          dvs_r <= den_pow;
        end
        val_r <= (st.branch == ri709_pkg::BR_FULL) ? s_r : 17'd0;
      end
      ri709_pkg::CMD_DIV_STEP: begin
        rem_r <= ge ? 27'(rem2 - {1'b0, dvs_r}) : rem2[26:0];
        dvd_r <= {dvd_r[62:0], 1'b0};
        q_r   <= {q_r[62:0], ge};
      end
      ri709_pkg::CMD_LIN_DONE: val_r <= q_r[16:0];
      ri709_pkg::CMD_ROOT_INIT: begin
        r_r  <= q_r[FW-1:0];
        u_r  <= '0;
        bm_r <= {1'b1, {(FW-1){1'b0}}};
      end
      ri709_pkg::CMD_R_SQ, ri709_pkg::CMD_R_O, ri709_pkg::CMD_P_SQ,
      ri709_pkg::CMD_P_8, ri709_pkg::CMD_P_16, ri709_pkg::CMD_P_20:
        t1_r <= prod[2*FW-1:FW];
      ri709_pkg::CMD_R_Q, ri709_pkg::CMD_R_N, ri709_pkg::CMD_P_4:
        t2_r <= prod[2*FW-1:FW];
      ri709_pkg::CMD_R_CMP: begin
        if (t2_r <= r_r) u_r <= cand;
        bm_r <= bm_r >> 1;
      end
      ri709_pkg::CMD_SCALE: val_r <= scaled[48:32];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == ri709_pkg::CMD_OUT_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == ri709_pkg::CMD_OUT_LOAD) begin
      out_component    <= comp_r;
      out_sample_value <= sen_r ? val_r : 17'd0;
      out_enabled      <= sen_r;
      out_last         <= slast_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Inverse gamma unpack unit testbench
// Streams raw pixel bytes through the unit under several register settings,
// predicts every linearized sample with exact wide-integer rounding and
// checks each result word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

  localparam logic [ri709_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd4;  // unmapped register index
  localparam int HOLD_CYCLES = 2000;
  localparam int STALL_LIMIT = 10000;
  localparam int DRAIN_CYCLES = 300;
  localparam int TARGET_BYTES = 1850;

  typedef struct {
    logic [1:0]  comp;
    logic [16:0] value;
    logic        en;
    logic        last;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_component;
  logic [16:0] out_sample_value;
  logic out_enabled;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ri709_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ri709_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  rec709_inverse_gamma_rgb_unpack_unit dut (.*);

  always #1 clk = ~clk;

  // stimulus and expectation stores
  logic [7:0] pending_bytes[$];
  sample_t expected_samples[$];
  int mismatches = 0;
  int snd_idle_pct = 12;
  int rcv_idle_pct = 63;
  int hold_requests = 0;
  logic in_taken = 1'b0;

  // predictor copy of registers and stream position
  logic [15:0] p_max_color;
  logic [2:0]  p_enable;
  logic        p_format;
  logic [23:0] p_limit;
  logic [7:0]  p_high_byte;
  logic        p_phase;
  logic [1:0]  p_comp;
  logic [23:0] p_pixels;
  logic        p_finished;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // round half up of the linearized value of w/m, scaled by s
  function automatic int unsigned linearize_round(int unsigned w, int unsigned m,
                                                  int unsigned s);
    logic [1023:0] lhs;
    logic [1023:0] base;
    logic [1023:0] rhs;
    longint unsigned num;
    int unsigned a, lo, hi, mid;
    if (64'(1000) * w < 64'(81) * m) begin
      num = 64'(4) * w * s + 64'(9) * m;
      return int'(num / (64'(18) * m));
    end
    a = 1000 * w + 99 * m;
    lhs = 1;
    repeat (20) lhs = lhs * a;
    repeat (9) lhs = lhs * (2 * s);
    base = 1;
    repeat (20) base = base * (1099 * m);
    lo = 0;
    hi = s;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      rhs = base;
      repeat (9) rhs = rhs * (2 * mid - 1);
      if (lhs >= rhs) lo = mid; else hi = mid - 1;
    end
    return lo;
  endfunction

  // check results, advance the predictor, watch for stalls
  always @(posedge clk) begin : monitor
    int unsigned m, w, s, v;
    int unsigned lim;
    int stall_cycles;
    sample_t got, want;
    logic any_fire;
    if (!rst_n) begin
      p_max_color = 16'd255; p_enable = 3'd7; p_format = 1'b0; p_limit = 24'd1;
      p_high_byte = '0; p_phase = 1'b0; p_comp = '0; p_pixels = '0; p_finished = 1'b0;
      stall_cycles = 0;
      in_taken <= 1'b0;
    end else begin
      any_fire = (out_valid && out_ready) || (in_valid && in_ready) ||
                 (cfg_valid && cfg_ready);
      // compare an accepted result word with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = expected_samples.pop_front();
          if (out_component !== want.comp) report_mismatch("component", out_component, want.comp);
          if (out_sample_value !== want.value)
            report_mismatch("sample_value", out_sample_value, want.value);
          if (out_enabled !== want.en) report_mismatch("enabled", out_enabled, want.en);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
      // apply a register write
      if (cfg_valid && cfg_ready && cfg_index <= ri709_pkg::REG_PIX_LIMIT) begin
        case (cfg_index)
          ri709_pkg::REG_MAX_COLOR: p_max_color = cfg_data[15:0];
          ri709_pkg::REG_COMP_EN:   p_enable = cfg_data[2:0];
          ri709_pkg::REG_OUT_FMT:   p_format = cfg_data[0];
          default:                  p_limit = cfg_data[23:0];
        endcase
        p_high_byte = '0; p_phase = 1'b0; p_comp = '0; p_pixels = '0; p_finished = 1'b0;
      end
      // predict the result of an accepted byte
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready && !p_finished) begin
        m = (p_max_color == 0) ? 1 : p_max_color;
        if (m > 255 && !p_phase) begin
          p_high_byte = in_data_byte;
          p_phase = 1'b1;
        end else begin
          w = (m > 255) ? {p_high_byte, in_data_byte} : in_data_byte;
          p_phase = 1'b0;
          if (w > m) w = m;
          got.comp = (p_comp > 2) ? 2'd2 : p_comp;
          got.en = p_enable[got.comp];
          got.value = '0;
          got.last = 1'b0;
          if (got.en) begin
            s = p_format ? 32'd65536 : m;
            v = linearize_round(w, m, s);
            got.value = (v > 17'h1FFFF) ? 17'h1FFFF : v[16:0];
          end
          if (got.comp == 2) begin
            lim = (p_limit == 0) ? 1 : p_limit;
            p_pixels = p_pixels + 1'b1;
            if (p_pixels == lim) begin
              p_finished = 1'b1;
              got.last = 1'b1;
            end
            p_comp = '0;
          end else begin
            p_comp = got.comp + 1'b1;
          end
          expected_samples.push_back(got);
        end
      end
      // end the run if nothing moves for too long
      stall_cycles = any_fire ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // byte driver: hold a word until taken, else offer the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (pending_bytes.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
      in_valid <= 1'b1;
      in_data_byte <= pending_bytes.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin : receiver
    int hold_left;
    int holds_seen;
    if (!rst_n) begin
      hold_left = 0;
      holds_seen = 0;
      out_ready <= 1'b0;
    end else begin
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [ri709_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[ri709_pkg::CFG_DAT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain: all bytes taken, all results in, and let the engine settle
  task automatic wait_drained();
    wait (pending_bytes.size() == 0 && !in_valid && expected_samples.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(input int unsigned mc, input int unsigned w);
    if (mc > 255) pending_bytes.push_back(w[15:8]);
    pending_bytes.push_back(w[7:0]);
  endtask

  // one setting: directed corners of the range, then random samples
  task automatic run_setting(input int unsigned mc, input int unsigned en,
                             input int unsigned fmt, input int unsigned lim,
                             input int samples);
    int unsigned m, w, knee;
    int pick;
    write_reg(ri709_pkg::REG_MAX_COLOR, mc);
    write_reg(ri709_pkg::REG_COMP_EN, en);
    write_reg(ri709_pkg::REG_OUT_FMT, fmt);
    write_reg(ri709_pkg::REG_PIX_LIMIT, lim);
    m = (mc[15:0] == 0) ? 1 : mc[15:0];
    knee = (81 * m) / 1000;
    for (int i = 0; i < samples; i++) begin
      pick = (i < 6) ? i : $urandom_range(9);
      case (pick)
        0: w = 0;
        1: w = m;
        2: w = knee;
        3: w = knee + 1;
        4: w = (m > 255) ? 16'hFFFF : 8'hFF;
        5: w = m - 1;
        6: w = (m > 255) ? $urandom_range(65535) : $urandom_range(255);
        default: w = $urandom_range(m);
      endcase
      push_sample(m, w);
    end
    // trailing bytes land past the limit on short frames
    repeat (3) pending_bytes.push_back($urandom_range(255));
  endtask

  initial begin
    int unsigned mc, lim;
    int sent, round_no;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one pixel, then ignored bytes
    repeat (5) pending_bytes.push_back($urandom_range(255));
    wait_drained();
    // unmapped index must keep the finished stream finished
    write_reg(REG_SPARE, 24'h000000);
    write_reg(8'hFF, 24'hFFFFFF);
    repeat (2) pending_bytes.push_back($urandom_range(255));
    wait_drained();

    // directed settings, extremes included
    run_setting(255, 7, 0, 0, 9);
    wait_drained();
    run_setting(65535, 5, 1, 24'hFFFFFF, 9);
    wait_drained();
    run_setting(0, 2, 0, 3, 9);
    wait_drained();
    run_setting(256, 0, 1, 2, 6);
    wait_drained();

    // random settings across three idling styles
    sent = 0;
    round_no = 0;
    while (sent < TARGET_BYTES) begin
      if (sent > TARGET_BYTES / 3) begin
        snd_idle_pct = 63;
        rcv_idle_pct = 12;
      end
      if (sent > 2 * TARGET_BYTES / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case ($urandom_range(3))
        0: mc = $urandom_range(255, 1);
        1: mc = $urandom_range(65535, 256);
        2: mc = 255;
        default: mc = 65535;
      endcase
      lim = ($urandom_range(2) == 0) ? $urandom_range(20, 1) : $urandom_range(24'hFFFFFF, 100);
      run_setting(mc, $urandom_range(7), $urandom_range(1), lim, 40);
      sent += pending_bytes.size();
      // stall the receiver long enough to back up the input side
      if (round_no == 3) begin
        repeat (5) @(posedge clk);
        hold_requests++;
      end
      round_no++;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
